// ----- hw/rtl/bmse_pkg.sv -----
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared types and constants for the square-window binary mask erosion block.
// ----------------------------------------------------------------------------
package bmse_pkg;

  // item kinds carried on the input tuser bit
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indices
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned KSIZE_W    = 4;
  localparam int unsigned PAD_W      = 3;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned IDX_W      = 26;
  localparam int unsigned MAX_HEIGHT = 2048;

  // reset values of the registers
  localparam logic [KSIZE_W-1:0] KSIZE_RST  = 4'd3;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd480;

  // effective frame geometry
  typedef struct packed {
    logic [KSIZE_W-1:0] k;
    logic [PAD_W-1:0]   pad;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } geo_t;

  // per-item control flags handed from the scan stage to the core
  typedef struct packed {
    logic drain;
    logic pix_valid;
    logic first;
    logic row_zero;
    logic col_zero;
    logic emit;
    logic wrap;
  } item_t;

endpackage

// ----- hw/rtl/bmse_cfg.sv -----
// ----------------------------------------------------------------------------
// bmse_cfg
// Configuration registers and the effective window side and frame size.
// ----------------------------------------------------------------------------
module bmse_cfg #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_PAD   = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [bmse_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [bmse_pkg::CFG_DATA_W-1:0]   wr_data,
  output bmse_pkg::geo_t                    geo
);

  localparam int unsigned KCAP = 2 * MAX_PAD + 1;

  logic [bmse_pkg::KSIZE_W-1:0] ksize_r;
  logic [bmse_pkg::DIM_W-1:0]   width_r;
  logic [bmse_pkg::DIM_W-1:0]   height_r;
  logic [bmse_pkg::KSIZE_W-1:0] k_raised;
  logic [bmse_pkg::KSIZE_W-1:0] k_odd;
  logic [bmse_pkg::KSIZE_W-1:0] k_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r  <= bmse_pkg::KSIZE_RST;
      width_r  <= bmse_pkg::WIDTH_RST;
      height_r <= bmse_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      if (wr_index == bmse_pkg::REG_KERNEL_SIZE) begin
        ksize_r <= wr_data[bmse_pkg::KSIZE_W-1:0];
      end
      if (wr_index == bmse_pkg::REG_FRAME_WIDTH) begin
        width_r <= wr_data;
      end
      if (wr_index == bmse_pkg::REG_FRAME_HEIGHT) begin
        height_r <= wr_data;
      end
    end
  end

  always_comb begin
    // raise to three, make odd, cap at the built maximum
    k_raised = (ksize_r < 4'd3) ? 4'd3 : ksize_r;
    k_odd    = k_raised[0] ? k_raised : (k_raised + 4'd1);
    k_eff    = (32'(k_odd) > KCAP) ? bmse_pkg::KSIZE_W'(KCAP) : k_odd;

    geo.k   = k_eff;
    geo.pad = k_eff[bmse_pkg::KSIZE_W-1:1];

    if (width_r == '0) begin
      geo.w = 12'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      geo.w = bmse_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      geo.w = width_r;
    end

    if (height_r == '0) begin
      geo.h = 12'd1;
    end else if (32'(height_r) > bmse_pkg::MAX_HEIGHT) begin
      geo.h = bmse_pkg::DIM_W'(bmse_pkg::MAX_HEIGHT);
    end else begin
      geo.h = height_r;
    end
  end

endmodule

// ----- hw/rtl/bmse_scan.sv -----
// ----------------------------------------------------------------------------
// bmse_scan
// Input raster position, lag check and frame wrap for each accepted request.
// ----------------------------------------------------------------------------
module bmse_scan #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic                          opcode,
  input  logic                          pixel_valid,
  input  bmse_pkg::geo_t                geo,
  output bmse_pkg::item_t               item,
  output logic [$clog2(MAX_WIDTH)-1:0]  col
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [AW-1:0]                col_r;
  logic [AW-1:0]                col_nxt;
  logic [bmse_pkg::ROW_W-1:0]   row_r;
  logic [bmse_pkg::ROW_W-1:0]   row_nxt;
  logic [bmse_pkg::ROW_W-1:0]   row_c;
  logic [bmse_pkg::IDX_W-1:0]   idx;
  logic [bmse_pkg::IDX_W-1:0]   lag;
  logic                         col_end;
  logic                         row_end;
  logic                         is_drain;

  always_comb begin
    is_drain = (opcode == bmse_pkg::OP_DRAIN);

    // clamp in case the frame shrank
    col   = (32'(col_r) >= 32'(geo.w)) ? AW'(geo.w - 12'd1) : col_r;
    row_c = (32'(row_r) >= 32'(geo.h)) ? bmse_pkg::ROW_W'(geo.h - 12'd1) : row_r;

    idx = bmse_pkg::IDX_W'(row_c) * bmse_pkg::IDX_W'(geo.w) + bmse_pkg::IDX_W'(col);
    lag = bmse_pkg::IDX_W'(geo.pad) * bmse_pkg::IDX_W'(geo.w) + bmse_pkg::IDX_W'(geo.pad);

    col_end = (32'(col) + 32'd1 >= 32'(geo.w));
    row_end = (32'(row_c) + 32'd1 >= 32'(geo.h));

    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : (row_c + 11'd1);
    end else begin
      col_nxt = col + AW'(1);
      row_nxt = row_c;
    end

    item.drain     = is_drain;
    item.pix_valid = pixel_valid;
    item.first     = !is_drain && (row_c == '0) && (col == '0);
    item.row_zero  = (row_c == '0);
    item.col_zero  = (col == '0);
    item.emit      = !is_drain && (idx >= lag);
    item.wrap      = !is_drain && col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (fire && !is_drain) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmse_run_mem.sv -----
// ----------------------------------------------------------------------------
// bmse_run_mem
// Per-column vertical run store, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module bmse_run_mem #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [bmse_pkg::RUN_W-1:0]     wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [bmse_pkg::RUN_W-1:0]     rdata
);

  logic [bmse_pkg::RUN_W-1:0] mem_r [DEPTH];
  logic [bmse_pkg::RUN_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/bmse_core.sv -----
// ----------------------------------------------------------------------------
// bmse_core
// Run update, window test, output position tracking and the result register.
// ----------------------------------------------------------------------------
module bmse_core #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmse_pkg::geo_t                      geo,
  input  logic                                in_fire,
  input  bmse_pkg::item_t                     in_item,
  input  logic [$clog2(MAX_WIDTH)-1:0]        in_col,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_support,
  output logic [bmse_pkg::COORD_W-1:0]        out_row,
  output logic [bmse_pkg::COORD_W-1:0]        out_col,
  output logic                                out_last
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // stage register
  logic                          s1_valid_r;
  bmse_pkg::item_t               s1_item_r;
  logic [AW-1:0]                 s1_col_r;
  logic                          s1_fire;

  // forwarding of a run written in the same cycle it was read
  logic                          byp_r;
  logic                          byp_nxt;
  logic [bmse_pkg::RUN_W-1:0]    byp_data_r;
  logic [bmse_pkg::RUN_W-1:0]    rd_data;

  // running state
  logic [bmse_pkg::RUN_W-1:0]    hrun_r;
  logic [bmse_pkg::RUN_W-1:0]    hrun_nxt;
  logic [AW-1:0]                 ocol_r;
  logic [AW-1:0]                 ocol_nxt;
  logic [bmse_pkg::ROW_W-1:0]    orow_r;
  logic [bmse_pkg::ROW_W-1:0]    orow_nxt;
  logic                          pend_r;
  logic                          pend_nxt;

  // result register
  logic                          out_valid_r;
  logic                          sup_r;
  logic [bmse_pkg::COORD_W-1:0]  orow_q_r;
  logic [bmse_pkg::COORD_W-1:0]  ocol_q_r;
  logic                          last_r;

  logic [bmse_pkg::RUN_W-1:0]    run_prev;
  logic [bmse_pkg::RUN_W:0]      run_sum;
  logic [bmse_pkg::RUN_W-1:0]    vrun;
  logic [bmse_pkg::RUN_W-1:0]    hbase;
  logic [bmse_pkg::RUN_W:0]      hsum;
  logic                          support;
  logic [AW-1:0]                 ocol_b;
  logic [bmse_pkg::ROW_W-1:0]    orow_b;
  logic                          pend_b;
  logic                          result;
  logic                          col_end;
  logic                          row_end;
  logic                          is_pix;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign is_pix   = !s1_item_r.drain;

  bmse_run_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_run_mem (
    .clk   (clk),
    .we    (s1_fire && is_pix),
    .waddr (s1_col_r),
    .wdata (vrun),
    .re    (in_fire),
    .raddr (in_col),
    .rdata (rd_data)
  );

  always_comb begin
    run_prev = byp_r ? byp_data_r : rd_data;
    run_sum  = {1'b0, run_prev} + 5'd1;

    // vertical run, saturating at the window side
    if (!s1_item_r.pix_valid) begin
      vrun = '0;
    end else if (s1_item_r.row_zero) begin
      vrun = 4'd1;
    end else if (run_sum > {1'b0, geo.k}) begin
      vrun = geo.k;
    end else begin
      vrun = run_sum[bmse_pkg::RUN_W-1:0];
    end

    hbase = s1_item_r.col_zero ? '0 : hrun_r;
    hsum  = {1'b0, hbase} + 5'd1;
    if (vrun >= geo.k) begin
      hrun_nxt = (hsum > {1'b0, geo.k}) ? geo.k : hsum[bmse_pkg::RUN_W-1:0];
    end else begin
      hrun_nxt = '0;
    end
    support = (hrun_nxt >= geo.k);

    // first pixel of a frame restarts output counting
    orow_b = (is_pix && s1_item_r.first) ? '0 : orow_r;
    ocol_b = (is_pix && s1_item_r.first) ? '0 : ocol_r;
    pend_b = (is_pix && s1_item_r.first) ? 1'b0 : pend_r;

    result  = is_pix ? s1_item_r.emit : pend_r;
    col_end = (32'(ocol_b) + 32'd1 >= 32'(geo.w));
    row_end = (32'(orow_b) + 32'd1 >= 32'(geo.h));

    orow_nxt = orow_b;
    ocol_nxt = ocol_b;
    pend_nxt = pend_b;
    if (result) begin
      if (col_end) begin
        ocol_nxt = '0;
        if (row_end) begin
          orow_nxt = '0;
          pend_nxt = 1'b0;
        end else begin
          orow_nxt = orow_b + 11'd1;
        end
      end else begin
        ocol_nxt = ocol_b + AW'(1);
      end
    end
    if (is_pix && s1_item_r.wrap) begin
      pend_nxt = 1'b1;
    end

    byp_nxt = s1_fire && is_pix && (s1_col_r == in_col);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
      hrun_r      <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        byp_r      <= byp_nxt;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire && result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        if (is_pix) begin
          hrun_r <= hrun_nxt;
        end
        ocol_r <= ocol_nxt;
        orow_r <= orow_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r  <= in_item;
      s1_col_r   <= in_col;
      byp_data_r <= vrun;
    end
    if (s1_fire && result) begin
      sup_r    <= is_pix ? support : 1'b0;
      orow_q_r <= bmse_pkg::COORD_W'(orow_b);
      ocol_q_r <= bmse_pkg::COORD_W'(ocol_b);
      last_r   <= col_end && row_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_support = sup_r;
  assign out_row     = orow_q_r;
  assign out_col     = ocol_q_r;
  assign out_last    = last_r;

  // same column back to back must take the forwarded run
  a_bypass_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && s1_fire && is_pix && (s1_col_r == in_col) |=> byp_r)
    else $error("forwarding missed for repeated column");

  // a held item is never dropped while the result side stalls
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r)
    else $error("stage item lost during stall");

  // a new result only comes from a completed stage item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire))
    else $error("result appeared without a processed item");

  // full pipeline and stalled output blocks new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("request accepted into a full pipeline");

endmodule

// ----- hw/rtl/binary_mask_square_erosion.sv -----
// ----------------------------------------------------------------------------
// binary_mask_square_erosion
// Streaming erosion of a binary validity mask by a square window.
// ----------------------------------------------------------------------------
// Takes one mask pixel per request in raster order and returns, for each pixel
// once enough of the frame has arrived, a support bit that is set only when the
// whole square window centred on it is valid, together with its row, column and
// an end-of-frame mark. The window side is kernel_size raised to 3, made odd and
// capped at 2*MAX_PAD+1; pixels within half a window of an edge read 0. Results
// trail the input by pad rows plus pad pixels; drain requests (tuser high) push
// out the trailing border zeros once the frame's last pixel is in, and a drain
// with nothing owed gives no result. One request is taken every clock unless the
// output stalls; the only loop is the per-column run counter, read at acceptance,
// written as the item leaves the stage register and forwarded when the column
// comes back next. Results pass the stage register, then the result register.
// The column run store holds MAX_WIDTH entries and needs no clearing pass,
// since the first row of a frame writes every column before it is read.
// Configuration writes are accepted every cycle and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module binary_mask_square_erosion #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_PAD   = 7
) (
  input  logic        clk,
  input  logic        rst_n,

  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,   // 0 kernel_size, 1 frame_width, 2 frame_height
  input  logic [11:0] cfg_data,

  // mask input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] pixel_valid, [7:1] zero
  input  logic        in_tuser,    // [0] opcode: 0 mask pixel, 1 drain

  // erosion result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [0] support, [11:1] out_row, [22:12] out_column, [23] zero
  output logic        out_tlast    // frame_last
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  bmse_pkg::geo_t                   geo;
  bmse_pkg::item_t                  item;
  logic [AW-1:0]                    col;
  logic                             in_fire;
  logic                             support;
  logic [bmse_pkg::COORD_W-1:0]     row_o;
  logic [bmse_pkg::COORD_W-1:0]     col_o;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  bmse_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PAD   (MAX_PAD)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geo      (geo)
  );

  // input raster position and lag test at acceptance
  bmse_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .opcode      (in_tuser),
    .pixel_valid (in_tdata[0]),
    .geo         (geo),
    .item        (item),
    .col         (col)
  );

  // run counters, window test and the result register
  bmse_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .geo         (geo),
    .in_fire     (in_fire),
    .in_item     (item),
    .in_col      (col),
    .in_ready    (in_tready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_support (support),
    .out_row     (row_o),
    .out_col     (col_o),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, col_o, row_o, support};

endmodule

// ----- dv/binary_mask_square_erosion_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_square_erosion_tb
// Self-checking bench for the streaming square-window mask erosion block.
// ----------------------------------------------------------------------------
// Streams mask frames and drain ticks into the block and checks every result
// (support, row, column, end-of-frame mark) against an in-bench model of the
// erosion. A short hand-built 4x4 frame comes first. Random small frames follow,
// with a few fixed shapes (one row, one column, the largest window), all window
// sides, a few register changes part-way through a frame, and frames whose drain
// is cut short. Both stream sides idle at random, with one long stretch of full
// rate. The result side also holds off once for a long while, so the block fills
// and stalls its input.
// ----------------------------------------------------------------------------
module binary_mask_square_erosion_tb;

  localparam int unsigned PAD_MAX       = 7;
  localparam int unsigned WIDTH_MAX     = 2048;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned IDLE_PCT      = 16;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned SMALL_PIXELS  = 200;

  typedef struct packed {
    logic op;
    logic pix;
  } mask_req_t;

  typedef struct packed {
    logic        support;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
  } eroded_px_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = bmse_pkg::REG_KERNEL_SIZE;
  logic [11:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [0] pixel_valid, [7:1] zero
  logic        in_tuser   = bmse_pkg::OP_PIXEL;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [0] support, [11:1] out_row, [22:12] out_column, [23] zero
  logic        out_tlast;         // frame_last

  binary_mask_square_erosion dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // requests waiting for the driver, and results the model says are owed
  mask_req_t  mask_reqs[$];
  eroded_px_t eroded_due[$];

  // model copy of the registers and of the block state
  logic [3:0]  kernel_reg = bmse_pkg::KSIZE_RST;
  logic [11:0] width_reg  = bmse_pkg::WIDTH_RST;
  logic [11:0] height_reg = bmse_pkg::HEIGHT_RST;
  logic [3:0]  col_run [WIDTH_MAX] = '{default: '0};
  int unsigned row_run = 0;
  int unsigned in_r = 0, in_c = 0;
  int unsigned out_r = 0, out_c = 0;
  bit          owed = 1'b0;

  // bench control and bookkeeping
  logic        in_took   = 1'b0;
  bit          steady    = 1'b0;
  bit          hold_go   = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet     = 0;
  int unsigned mismatches = 0;
  int unsigned n_reqs = 0, n_drains = 0, n_results = 0, n_support = 0;
  int unsigned max_row = 0, max_col = 0;

  function automatic int unsigned clamp_dim(input logic [11:0] d, input int unsigned lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return d;
  endfunction

  // window side: at least 3, odd, no wider than the built pad allows
  function automatic int unsigned win_side();
    int unsigned s;
    s = kernel_reg;
    if (s < 3) s = 3;
    if (s % 2 == 0) s++;
    if (s > 2 * PAD_MAX + 1) s = 2 * PAD_MAX + 1;
    return s;
  endfunction

  // moves a raster position on by one, high when it wraps past the frame
  function automatic bit step_raster(inout int unsigned r, inout int unsigned c,
                                     input int unsigned w, input int unsigned h);
    if (c + 1 >= w) begin
      c = 0;
      if (r + 1 >= h) begin
        r = 0;
        return 1'b1;
      end
      r++;
      return 1'b0;
    end
    c++;
    return 1'b0;
  endfunction

  // positions from (r, c) to the end of the frame, both included
  function automatic int unsigned raster_left(input int unsigned r, input int unsigned c,
                                              input int unsigned w, input int unsigned h);
    if (r >= h) r = h - 1;
    if (c >= w) c = w - 1;
    return (h - 1 - r) * w + (w - 1 - c) + 1;
  endfunction

  function automatic void owe_pixel(input logic sup, input int unsigned w, input int unsigned h);
    eroded_px_t px;
    px.support = sup;
    px.row     = 11'(out_r);
    px.col     = 11'(out_c);
    px.last    = (out_r + 1 >= h) && (out_c + 1 >= w);
    eroded_due.push_back(px);
    if (step_raster(out_r, out_c, w, h)) owed = 1'b0;
  endfunction

  // one accepted request through the erosion: run counters, lag, drain
  function automatic void erode_pixel(input mask_req_t rq);
    int unsigned w, h, k, pad, r, c, v;
    w   = clamp_dim(width_reg, WIDTH_MAX);
    h   = clamp_dim(height_reg, bmse_pkg::MAX_HEIGHT);
    k   = win_side();
    pad = k / 2;
    if (rq.op == bmse_pkg::OP_DRAIN) begin
      if (owed) owe_pixel(1'b0, w, h);
      return;
    end
    r = (in_r >= h) ? h - 1 : in_r;
    c = (in_c >= w) ? w - 1 : in_c;
    // a new frame drops whatever the last one still owed
    if (r == 0 && c == 0) begin
      owed  = 1'b0;
      out_r = 0;
      out_c = 0;
    end
    v = 0;
    if (rq.pix) begin
      v = (r == 0) ? 1 : col_run[c] + 1;
      if (v > k) v = k;
    end
    col_run[c] = 4'(v);
    if (c == 0) row_run = 0;
    if (v >= k) begin
      row_run++;
      if (row_run > k) row_run = k;
    end else begin
      row_run = 0;
    end
    if (r * w + c >= pad * w + pad) owe_pixel(row_run >= k, w, h);
    in_r = r;
    in_c = c;
    if (step_raster(in_r, in_c, w, h)) owed = 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30) $display("%0t mismatch: %s", $time, msg);
  endtask

  // driver: next request on the falling edge once the current one is taken
  always @(negedge clk) begin : driver
    mask_req_t rq;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (mask_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        rq = mask_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= rq.op;
        in_tdata  <= {7'd0, rq.pix};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin : sink
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: checks results, then feeds accepted requests to the model
  always @(posedge clk) begin : monitor
    eroded_px_t got, want;
    mask_req_t  rq;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got.support = out_tdata[0];
        got.row     = out_tdata[11:1];
        got.col     = out_tdata[22:12];
        got.last    = out_tlast;
        n_results++;
        if (got.support) n_support++;
        if (got.row > max_row) max_row = got.row;
        if (got.col > max_col) max_col = got.col;
        if (eroded_due.size() == 0) begin
          flag_mismatch($sformatf("result row %0d column %0d with nothing owed",
                                  got.row, got.col));
        end else begin
          want = eroded_due.pop_front();
          if (got.support != want.support)
            flag_mismatch($sformatf("result %0d support %0d, want %0d",
                                    n_results, got.support, want.support));
          if (got.row != want.row)
            flag_mismatch($sformatf("result %0d row %0d, want %0d",
                                    n_results, got.row, want.row));
          if (got.col != want.col)
            flag_mismatch($sformatf("result %0d column %0d, want %0d",
                                    n_results, got.col, want.col));
          if (got.last != want.last)
            flag_mismatch($sformatf("result %0d frame_last %0d, want %0d",
                                    n_results, got.last, want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        rq.op  = in_tuser;
        rq.pix = in_tdata[0];
        n_reqs++;
        if (rq.op == bmse_pkg::OP_DRAIN) n_drains++;
        erode_pixel(rq);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: %0d cycles with no transfer, %0d results owed, %0d requests unsent",
             quiet, eroded_due.size(), mask_reqs.size());
    $display("binary_mask_square_erosion_tb: errors");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bmse_pkg::REG_KERNEL_SIZE:  kernel_reg = val[3:0];
      bmse_pkg::REG_FRAME_WIDTH:  width_reg  = val;
      bmse_pkg::REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every request is in and every owed result is out
  task automatic settle();
    while (mask_reqs.size() != 0 || in_tvalid || eroded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixels(input int unsigned n, input int unsigned holes);
    repeat (n) mask_reqs.push_back('{op: bmse_pkg::OP_PIXEL,
                                     pix: ($urandom_range(99) >= holes)});
  endtask

  task automatic queue_drains(input int unsigned n);
    repeat (n) mask_reqs.push_back('{op: bmse_pkg::OP_DRAIN, pix: 1'($urandom)});
  endtask

  initial begin : stimulus
    int unsigned phase, k_req, w_req, h_req, holes, n, split, w, h, sel;
    int unsigned small_pixels, n_frames, n_mid, n_cut;
    bit          special;
    small_pixels = 0;
    n_frames     = 0;
    n_mid        = 0;
    n_cut        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // hand-built 4x4 frame, 3x3 window: two holes knock out three of the four
    // inner pixels; a drain before anything is owed and one after the flush
    write_reg(bmse_pkg::REG_KERNEL_SIZE, 12'd3);
    write_reg(bmse_pkg::REG_FRAME_WIDTH, 12'd4);
    write_reg(bmse_pkg::REG_FRAME_HEIGHT, 12'd4);
    queue_drains(1);
    for (int i = 0; i < 16; i++)
      mask_reqs.push_back('{op: bmse_pkg::OP_PIXEL, pix: (i != 3 && i != 14)});
    queue_drains(6);
    settle();
    n_frames++;

    // random frames, mostly small; a few fixed phases for the extremes
    phase = 0;
    while (small_pixels < SMALL_PIXELS || phase < 11) begin
      special = 1'b1;
      holes   = 0;
      case (phase)
        1: begin k_req = 0;  w_req = 24;   h_req = 0;    end   // one row high
        3: begin k_req = 3;  w_req = 12;   h_req = 12;   end   // hold-off frame
        4: begin k_req = 15; w_req = 16;   h_req = 16;   end   // largest window, fully valid
        7: begin k_req = 14; w_req = 0;    h_req = 24;   end   // one column wide
        default: begin
          special = 1'b0;
          k_req   = $urandom_range(15);
          w_req   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
          h_req   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
          case ($urandom_range(4))
            0, 1: holes = 0;
            2: holes = 5;
            3: holes = 20;
            default: holes = 50;
          endcase
        end
      endcase
      steady = (phase >= 8 && phase < 14);

      // sometimes keep the old geometry
      if (special || phase == 0 || $urandom_range(3) != 0) begin
        settle();
        write_reg(bmse_pkg::REG_KERNEL_SIZE, {8'($urandom), 4'(k_req)});
        write_reg(bmse_pkg::REG_FRAME_WIDTH, 12'(w_req));
        write_reg(bmse_pkg::REG_FRAME_HEIGHT, 12'(h_req));
      end
      w = clamp_dim(width_reg, WIDTH_MAX);
      h = clamp_dim(height_reg, bmse_pkg::MAX_HEIGHT);
      n = w * h;

      if (!special && n >= 4 && $urandom_range(4) == 0) begin
        // register change part-way through the frame; width only shrinks so
        // no column is read before this frame has written it
        split = $urandom_range(1, n - 1);
        queue_pixels(split, holes);
        settle();
        sel = $urandom_range(2);
        if (sel == 0)
          write_reg(bmse_pkg::REG_KERNEL_SIZE, 12'($urandom_range(15)));
        else if (sel == 1)
          write_reg(bmse_pkg::REG_FRAME_WIDTH, 12'($urandom_range(1, w)));
        else
          write_reg(bmse_pkg::REG_FRAME_HEIGHT, 12'($urandom_range(12)));
        w = clamp_dim(width_reg, WIDTH_MAX);
        h = clamp_dim(height_reg, bmse_pkg::MAX_HEIGHT);
        n = raster_left(in_r, in_c, w, h);
        queue_pixels(n, holes);
        n = n + split;
        n_mid++;
      end else begin
        queue_pixels(n, holes);
      end
      if (phase == 3) hold_go = 1'b1;
      if (!special) small_pixels += n;

      // flush the trailing border, now and then cut short so the next frame drops it
      settle();
      n = owed ? raster_left(out_r, out_c, w, h) : 0;
      if (n != 0 && $urandom_range(7) == 0) begin
        n = $urandom_range(n - 1);
        n_cut++;
      end else begin
        n = n + $urandom_range(2);
      end
      queue_drains(n);
      n_frames++;
      phase++;
    end

    steady = 1'b0;
    settle();
    $display("summary: %0d frames, %0d requests (%0d drain ticks), %0d results, %0d with support",
             n_frames, n_reqs, n_drains, n_results, n_support);
    $display("summary: %0d mid-frame register changes, %0d short drains, top row %0d, top column %0d",
             n_mid, n_cut, max_row, max_col);
    if (mismatches == 0)
      $display("binary_mask_square_erosion_tb: clean");
    else
      $display("binary_mask_square_erosion_tb: errors");
    $finish;
  end

endmodule
